### src/rsfl_pkg.sv
// Package for the record store with free list.
// Holds the operation and status codes, the command struct and the fixed field widths.
// No dependencies.
package rsfl_pkg;

    localparam int FUNC_W      = 3;
    localparam int REC_IDX_W   = 8;
    localparam int FIELD_SEL_W = 2;
    localparam int DATA_W      = 32;
    localparam int COUNT_OUT_W = 9;
    localparam int STATUS_W    = 2;
    localparam int CFG_W       = 3;

    // command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    typedef enum logic [FUNC_W-1:0] {
        OP_GET    = 3'd0,
        OP_SET    = 3'd1,
        OP_PUSH   = 3'd2,
        OP_POP    = 3'd3,
        OP_INSERT = 3'd4,
        OP_ERASE  = 3'd5,
        OP_CLEAR  = 3'd6,
        OP_BAD    = 3'd7
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic {
        BS_IDLE = 1'b0,
        BS_WAIT = 1'b1
    } t_back_state;

    typedef struct packed {
        t_op                      op;
        logic [REC_IDX_W-1:0]     record_index;
        logic [FIELD_SEL_W-1:0]   field_select;
        logic                     field_ok;
        logic signed [DATA_W-1:0] write_value;
    } t_cmd;

endpackage

### src/rsfl_chan_if.sv
// Handshake channel interfaces for the record store: request and response items.
// Depends on rsfl_pkg.
interface rsfl_req_if;
    import rsfl_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [FUNC_W-1:0]             func;
    logic [REC_IDX_W-1:0]          record_index;
    logic [FIELD_SEL_W-1:0]        field_select;
    logic signed [DATA_W-1:0]      write_value;

    modport source (output valid, func, record_index, field_select, write_value,
                    input ready);
    modport sink   (input valid, func, record_index, field_select, write_value,
                    output ready);
endinterface

interface rsfl_rsp_if;
    import rsfl_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [REC_IDX_W-1:0]          allocated_index;
    logic signed [DATA_W-1:0]      read_value;
    logic [COUNT_OUT_W-1:0]        record_count;
    logic [STATUS_W-1:0]           status;

    modport source (output valid, allocated_index, read_value, record_count, status,
                    input ready);
    modport sink   (input valid, allocated_index, read_value, record_count, status,
                    output ready);
endinterface

### src/rsfl_front.sv
// Front end: holds the field-count register, decodes request items, queues commands.
// Depends on rsfl_pkg and rsfl_req_if.
module rsfl_front #(
    parameter int MAX_FIELDS = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [rsfl_pkg::CFG_W-1:0]  i_cfg_wdata,
    rsfl_req_if.sink                    i_req,
    output logic                        o_cmd_valid,
    output rsfl_pkg::t_cmd              o_cmd,
    input  logic                        i_cmd_pop
);
    import rsfl_pkg::*;

    logic [CFG_W-1:0] r_fields;
    t_cmd             r_q [Q_DEPTH];
    logic [Q_AW-1:0]  r_wp;
    logic [Q_AW-1:0]  r_rp;
    logic [Q_AW:0]    r_fill;

    t_cmd             dec;
    logic             push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fields <= CFG_W'(1);
        end else if (i_cfg_we) begin
            r_fields <= i_cfg_wdata;
        end
    end

    // field must be below max(cfg, 1) and below MAX_FIELDS
    always_comb begin
        dec.op           = t_op'(i_req.func);
        dec.record_index = i_req.record_index;
        dec.field_select = i_req.field_select;
        dec.write_value  = i_req.write_value;
        dec.field_ok     = ((i_req.field_select == '0)
                            || (CFG_W'(i_req.field_select) < r_fields))
                           && (32'(i_req.field_select) < MAX_FIELDS);
    end

    assign i_req.ready = (r_fill != (Q_AW+1)'(Q_DEPTH));
    assign push        = i_req.valid && i_req.ready;
    assign o_cmd_valid = (r_fill != '0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_cmd_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !i_cmd_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (!push && i_cmd_pop) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

### src/rsfl_back.sv
// Back end: record memory, count, free-list head, execution sequencer and result register.
// Depends on rsfl_pkg and rsfl_rsp_if.
module rsfl_back #(
    parameter int MAX_RECORDS = 256,
    parameter int MAX_FIELDS  = 4,
    parameter int VALUE_BITS  = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  rsfl_pkg::t_cmd  i_cmd,
    output logic            o_cmd_pop,
    rsfl_rsp_if.source      o_rsp
);
    import rsfl_pkg::*;

    localparam int IW    = $clog2(MAX_RECORDS);
    localparam int CW    = $clog2(MAX_RECORDS + 1);
    localparam int DEPTH = MAX_RECORDS * MAX_FIELDS;
    localparam int AW    = $clog2(DEPTH);

    logic [VALUE_BITS-1:0] r_mem [DEPTH];
    logic [VALUE_BITS-1:0] r_rd_data;

    t_back_state              r_state, n_state;
    t_cmd                     r_cmd;
    logic [CW-1:0]            r_count, n_count;
    logic                     r_head_vld, n_head_vld;
    logic [IW-1:0]            r_head, n_head;

    logic                     r_out_valid, n_out_valid;
    logic [REC_IDX_W-1:0]     r_alloc, n_alloc;
    logic signed [DATA_W-1:0] r_rval, n_rval;
    logic [COUNT_OUT_W-1:0]   r_cnt_out, n_cnt_out;
    t_status                  r_status, n_status;

    logic                     mem_we;
    logic                     mem_re;
    logic [AW-1:0]            mem_addr;
    logic [VALUE_BITS-1:0]    mem_wdata;

    logic                     take;
    logic                     rec_ok;
    logic [IW-1:0]            rec_iw;
    logic                     full;
    logic                     link_end;

    assign rec_iw   = IW'(i_cmd.record_index);
    assign rec_ok   = (17'(i_cmd.record_index) < 17'(r_count))
                      && (32'(i_cmd.record_index) < MAX_RECORDS);
    assign full     = (32'(r_count) >= MAX_RECORDS);
    assign link_end = (r_rd_data == '1) || (65'(r_rd_data) >= 65'(MAX_RECORDS));
    assign take     = (r_state == BS_IDLE) && i_cmd_valid
                      && (!r_out_valid || o_rsp.ready);
    assign o_cmd_pop = take;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_head_vld  = r_head_vld;
        n_head      = r_head;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_alloc     = r_alloc;
        n_rval      = r_rval;
        n_cnt_out   = r_cnt_out;
        n_status    = r_status;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = AW'(rec_iw) * AW'(MAX_FIELDS) + AW'(i_cmd.field_select);
        mem_wdata   = VALUE_BITS'(i_cmd.write_value);

        case (r_state)
            BS_IDLE: begin
                if (take) begin
                    n_out_valid = 1'b1;
                    n_alloc     = '0;
                    n_rval      = '0;
                    n_status    = ST_OK;
                    case (i_cmd.op)
                        OP_GET: begin
                            if (rec_ok && i_cmd.field_ok) begin
                                mem_re      = 1'b1;
                                n_out_valid = 1'b0;
                                n_state     = BS_WAIT;
                            end else begin
                                n_status = ST_RANGE;
                            end
                        end
                        OP_SET: begin
                            if (rec_ok && i_cmd.field_ok) begin
                                mem_we = 1'b1;
                            end else begin
                                n_status = ST_RANGE;
                            end
                        end
                        OP_PUSH, OP_INSERT: begin
                            if (i_cmd.op == OP_INSERT && r_head_vld) begin
                                // reuse the free-list head; its link is read next cycle
                                mem_addr    = AW'(r_head) * AW'(MAX_FIELDS);
                                mem_re      = 1'b1;
                                n_out_valid = 1'b0;
                                n_state     = BS_WAIT;
                            end else if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_alloc = REC_IDX_W'(r_count);
                                n_count = r_count + 1'b1;
                            end
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_count = r_count - 1'b1;
                            end
                        end
                        OP_ERASE: begin
                            if (rec_ok) begin
                                mem_we     = 1'b1;
                                mem_addr   = AW'(rec_iw) * AW'(MAX_FIELDS);
                                mem_wdata  = r_head_vld ? VALUE_BITS'(r_head) : '1;
                                n_head     = rec_iw;
                                n_head_vld = 1'b1;
                            end else begin
                                n_status = ST_RANGE;
                            end
                        end
                        OP_CLEAR: begin
                            n_count    = '0;
                            n_head_vld = 1'b0;
                        end
                        default: begin
                            n_status = ST_RANGE;
                        end
                    endcase
                    n_cnt_out = COUNT_OUT_W'(n_count);
                end
            end
            BS_WAIT: begin
                // result slot was free when the command was taken
                n_out_valid = 1'b1;
                n_state     = BS_IDLE;
                if (r_cmd.op == OP_GET) begin
                    n_rval = DATA_W'(r_rd_data);
                end else begin
                    n_alloc = REC_IDX_W'(r_head);
                    if (link_end) begin
                        n_head_vld = 1'b0;
                    end else begin
                        n_head = IW'(r_rd_data);
                    end
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= i_cmd;
        end
        r_alloc   <= n_alloc;
        r_rval    <= n_rval;
        r_cnt_out <= n_cnt_out;
        r_status  <= n_status;
        r_head    <= n_head;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_count     <= '0;
            r_head_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_head_vld  <= n_head_vld;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.allocated_index = r_alloc;
    assign o_rsp.read_value      = r_rval;
    assign o_rsp.record_count    = r_cnt_out;
    assign o_rsp.status          = r_status;

endmodule

### src/record_store_with_free_list_top.sv
// Record store with free list, top level: front decode/queue plus back execution unit.
// A result passes the front command queue and the back-end result register; a get and an
// insert reusing a free record also pass the registered memory read. Throughput: one item
// per cycle while results are taken; get and free-list insert stall for the read.
// Reset clears count, free-list head, queue and field-count register (to 1); the record
// memory is not cleared and holds garbage until written.
// Depends on rsfl_pkg, rsfl_chan_if, rsfl_front, rsfl_back.
module record_store_with_free_list_top #(
    parameter int MAX_RECORDS = 256,
    parameter int MAX_FIELDS  = 4,
    parameter int VALUE_BITS  = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [rsfl_pkg::CFG_W-1:0]  i_cfg_wdata,
    rsfl_req_if.sink                    i_req,
    rsfl_rsp_if.source                  o_rsp
);
    import rsfl_pkg::*;

    // Command queue handoff: front classifies (op, field range) and buffers up to
    // Q_DEPTH items; back checks record range against the live count and executes.
    logic cmd_valid;
    logic cmd_pop;
    t_cmd cmd;

    rsfl_front #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_req),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // Back end owns the record memory (MAX_RECORDS x MAX_FIELDS words), the count,
    // the free-list head and the result register; erased records link through field 0.
    rsfl_back #(
        .MAX_RECORDS (MAX_RECORDS),
        .MAX_FIELDS  (MAX_FIELDS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_rsp       (o_rsp)
    );

endmodule

### sim/rsfl_store_checker.sv
`timescale 1ns / 1ps
// Result checker for the record store: keeps its own copy of the store, free list and field count.
// Predicts one result per accepted item and compares the results in order. Depends on rsfl_pkg, rsfl_chan_if.
module rsfl_store_checker #(
    parameter int N_REC = 256,
    parameter int N_FLD = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rsfl_pkg::CFG_W-1:0]    i_cfg_wdata,
    rsfl_req_if                           i_req,
    rsfl_rsp_if                           i_rsp,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_count,
    output int                            o_fields,
    output logic [N_REC*N_FLD-1:0]        o_written
);
    import rsfl_pkg::*;

    localparam logic [DATA_W-1:0] LINK_NONE = '1;

    typedef struct packed {
        logic [REC_IDX_W-1:0]     alloc;
        logic signed [DATA_W-1:0] rdata;
        logic [COUNT_OUT_W-1:0]   cnt;
        t_status                  st;
    } t_store_result;

    logic [DATA_W-1:0]      store_mem [N_REC*N_FLD];
    logic [N_REC*N_FLD-1:0] written_map;
    int                     in_use;
    int                     free_head;      // -1: free list empty
    logic [CFG_W-1:0]       fields_reg;
    t_store_result          expected_results [$];
    int                     mismatch_count = 0;

    function automatic int active_fields();
        if (fields_reg == 0)
            return 1;
        if (int'(fields_reg) > N_FLD)
            return N_FLD;
        return int'(fields_reg);
    endfunction

    task automatic predict_store_op(input t_op op, input logic [REC_IDX_W-1:0] rec,
                                    input logic [FIELD_SEL_W-1:0] fld,
                                    input logic [DATA_W-1:0] wval,
                                    output t_store_result res);
        bit                rec_ok;
        bit                fld_ok;
        int                addr;
        logic [DATA_W-1:0] link;
        rec_ok = int'(rec) < in_use;
        fld_ok = int'(fld) < active_fields();
        addr   = int'(rec) * N_FLD + int'(fld);
        res    = '0;
        res.st = ST_OK;
        case (op)
            OP_GET: begin
                if (rec_ok && fld_ok)
                    res.rdata = store_mem[addr];
                else
                    res.st = ST_RANGE;
            end
            OP_SET: begin
                if (rec_ok && fld_ok) begin
                    store_mem[addr]   = wval;
                    written_map[addr] = 1'b1;
                end else begin
                    res.st = ST_RANGE;
                end
            end
            OP_PUSH, OP_INSERT: begin
                if (op == OP_INSERT && free_head >= 0) begin
                    // reuse the list head, follow its link in field 0
                    res.alloc = free_head[REC_IDX_W-1:0];
                    link      = store_mem[free_head * N_FLD];
                    if (link == LINK_NONE || link >= N_REC)
                        free_head = -1;
                    else
                        free_head = int'(link);
                end else if (in_use >= N_REC) begin
                    res.st = ST_FULL;
                end else begin
                    res.alloc = in_use[REC_IDX_W-1:0];
                    in_use++;
                end
            end
            OP_POP: begin
                if (in_use == 0)
                    res.st = ST_EMPTY;
                else
                    in_use--;
            end
            OP_ERASE: begin
                if (rec_ok) begin
                    store_mem[int'(rec) * N_FLD]   = (free_head < 0) ? LINK_NONE
                                                                     : DATA_W'(free_head);
                    written_map[int'(rec) * N_FLD] = 1'b1;
                    free_head                      = int'(rec);
                end else begin
                    res.st = ST_RANGE;
                end
            end
            OP_CLEAR: begin
                in_use    = 0;
                free_head = -1;
            end
            default: res.st = ST_RANGE;
        endcase
        res.cnt = in_use[COUNT_OUT_W-1:0];
    endtask

    always @(posedge i_clk) begin : watch
        t_store_result want;
        t_store_result got;
        if (!i_rst_n) begin
            in_use      = 0;
            free_head   = -1;
            fields_reg  = 1;
            written_map = '0;
            expected_results.delete();
        end else begin
            // results first: a result never belongs to an item taken at the same edge
            if (i_rsp.valid && i_rsp.ready) begin
                got.alloc = i_rsp.allocated_index;
                got.rdata = i_rsp.read_value;
                got.cnt   = i_rsp.record_count;
                got.st    = t_status'(i_rsp.status);
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result alloc %0d data %0h count %0d status %0d",
                             $time, got.alloc, got.rdata, got.cnt, got.st);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.alloc !== want.alloc) begin
                        $display("%0t: allocated_index expected %0d, got %0d",
                                 $time, want.alloc, got.alloc);
                        mismatch_count++;
                    end
                    if (got.rdata !== want.rdata) begin
                        $display("%0t: read_value expected %0h, got %0h",
                                 $time, want.rdata, got.rdata);
                        mismatch_count++;
                    end
                    if (got.cnt !== want.cnt) begin
                        $display("%0t: record_count expected %0d, got %0d",
                                 $time, want.cnt, got.cnt);
                        mismatch_count++;
                    end
                    if (got.st !== want.st) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.st, got.st);
                        mismatch_count++;
                    end
                end
            end
            if (i_cfg_we)
                fields_reg = i_cfg_wdata;
            if (i_req.valid && i_req.ready) begin
                predict_store_op(t_op'(i_req.func), i_req.record_index, i_req.field_select,
                                 i_req.write_value, want);
                expected_results.push_back(want);
            end
        end
        o_fail_count = mismatch_count;
        o_pending    = expected_results.size();
        o_count      = in_use;
        o_fields     = active_fields();
        o_written    = written_map;
    end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the record store with free list: clock, reset, config writes and item stimulus.
// The checker predicts and compares; this module gives the verdict. Depends on rsfl_pkg, rsfl_chan_if, the RTL.
module tb_top;
    import rsfl_pkg::*;

    localparam int NUM_REC        = 256;
    localparam int NUM_FLD        = 4;
    localparam int NUM_SEG        = 8;
    localparam int FILL_SEG       = 2;     // segment that runs the store up to full
    localparam int DRAIN_CYCLES   = 4;     // idle cycles before a field-count write
    localparam int TAIL_CYCLES    = 10;
    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no item moving on either channel

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    rsfl_req_if req_ch ();
    rsfl_rsp_if rsp_ch ();

    int                     chk_fails;
    int                     chk_pending;
    int                     chk_count;
    int                     chk_fields;
    logic [NUM_REC*NUM_FLD-1:0] chk_written;

    int src_idle_pct;
    int dst_idle_pct;
    int quiet_cycles = 0;

    record_store_with_free_list_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    rsfl_store_checker #(
        .N_REC (NUM_REC),
        .N_FLD (NUM_FLD)
    ) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (chk_fails),
        .o_pending    (chk_pending),
        .o_count      (chk_count),
        .o_fields     (chk_fields),
        .o_written    (chk_written)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver side: ready is redrawn on every falling edge.
    always @(negedge i_clk) begin
        rsp_ch.ready = ($urandom_range(0, 99) >= dst_idle_pct);
    end

    // Watchdog: any accepted item on either channel restarts the count.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Mostly random data, with corners and small values that look like free-list links
    // (some of them past the last record, which ends the list).
    function automatic logic [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return '1;
                    2:       return 32'h8000_0000;
                    default: return 32'h7FFF_FFFF;
                endcase
            end
            1:       return DATA_W'($urandom_range(0, 300));
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // Present one item and hold it until the block takes it. Called and returns on a
    // falling edge; valid is left high so back-to-back items need no gap.
    task automatic send_op(input t_op op, input logic [REC_IDX_W-1:0] rec,
                           input logic [FIELD_SEL_W-1:0] fld, input logic [DATA_W-1:0] wval);
        t_op use_op;
        use_op = op;
        // a get of a field never written has no defined answer: write it instead
        if (op == OP_GET && int'(rec) < chk_count && int'(fld) < chk_fields &&
            !chk_written[int'(rec) * NUM_FLD + int'(fld)])
            use_op = OP_SET;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid        = 1'b1;
        req_ch.func         = use_op;
        req_ch.record_index = rec;
        req_ch.field_select = fld;
        req_ch.write_value  = wval;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Write the field count only with the block idle: all results in, followed by a drain wait.
    task automatic write_fields(input logic [CFG_W-1:0] nf);
        req_ch.valid = 1'b0;
        while (chk_pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_wdata = nf;
        @(negedge i_clk);
        cfg_we    = 1'b0;
    endtask

    // Random item shaped by the current state: most indexes land inside the store,
    // with a share of out-of-range indexes and fields and some unknown operations.
    task automatic make_random_op(output t_op op, output logic [REC_IDX_W-1:0] rec,
                                  output logic [FIELD_SEL_W-1:0] fld,
                                  output logic [DATA_W-1:0] wval);
        int pick;
        pick = $urandom_range(0, 99);
        rec  = (chk_count > 0) ? REC_IDX_W'($urandom_range(0, chk_count - 1))
                               : REC_IDX_W'($urandom);
        fld  = FIELD_SEL_W'($urandom_range(0, chk_fields - 1));
        if ($urandom_range(0, 7) == 0)
            fld = FIELD_SEL_W'($urandom);
        wval = rand_value();
        if (pick < 20)
            op = OP_SET;
        else if (pick < 40)
            op = OP_GET;
        else if (pick < 54)
            op = OP_PUSH;
        else if (pick < 64)
            op = OP_INSERT;
        else if (pick < 73)
            op = OP_ERASE;
        else if (pick < 83)
            op = OP_POP;
        else if (pick < 86)
            op = OP_CLEAR;
        else if (pick < 94) begin
            // index anywhere, mostly past the end
            case ($urandom_range(0, 2))
                0:       op = OP_GET;
                1:       op = OP_SET;
                default: op = OP_ERASE;
            endcase
            rec = REC_IDX_W'($urandom);
        end else begin
            op  = OP_BAD;
            rec = REC_IDX_W'($urandom);
        end
    endtask

    initial begin : stimulus
        int               seg_items [NUM_SEG] = '{60, 60, 60, 60, 60, 60, 60, 60};
        logic [CFG_W-1:0] seg_fields [NUM_SEG] = '{3'd5, 3'd0, 3'd4, 3'd7, 3'd2, 3'd1, 3'd3, 3'd6};
        t_op                    op;
        logic [REC_IDX_W-1:0]   rec;
        logic [FIELD_SEL_W-1:0] fld;
        logic [DATA_W-1:0]      wval;

        i_rst_n             = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        req_ch.valid        = 1'b0;
        req_ch.func         = '0;
        req_ch.record_index = '0;
        req_ch.field_select = '0;
        req_ch.write_value  = '0;
        rsp_ch.ready        = 1'b0;
        src_idle_pct        = 21;
        dst_idle_pct        = 71;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, first with the reset field count of one.
        send_op(OP_POP,   8'd0,   2'd0, '0);           // pop on empty store
        send_op(OP_GET,   8'd0,   2'd0, '0);           // get with nothing in use
        send_op(OP_PUSH,  8'hFF,  2'd3, '1);           // unused fields all ones
        send_op(OP_SET,   8'd0,   2'd0, 32'h8000_0000);
        send_op(OP_SET,   8'd0,   2'd1, 32'd5);        // field past the field count
        send_op(OP_GET,   8'd0,   2'd0, '0);
        send_op(OP_BAD,   8'hAA,  2'd2, 32'h5555_5555);
        write_fields(3'd4);
        send_op(OP_PUSH,  8'd0,   2'd0, '0);
        send_op(OP_SET,   8'd1,   2'd3, 32'h7FFF_FFFF);
        send_op(OP_GET,   8'd1,   2'd3, '0);
        send_op(OP_SET,   8'd1,   2'd0, '1);
        send_op(OP_ERASE, 8'd0,   2'd0, '0);           // list was empty: link is all ones
        send_op(OP_ERASE, 8'd1,   2'd0, '0);           // links to record 0
        send_op(OP_INSERT, 8'd0,  2'd0, '0);           // reuses 1
        send_op(OP_INSERT, 8'd0,  2'd0, '0);           // reuses 0, list now empty
        send_op(OP_INSERT, 8'd0,  2'd0, '0);           // appends
        send_op(OP_GET,   8'd255, 2'd0, '0);           // index past the end
        send_op(OP_ERASE, 8'd2,   2'd0, '0);
        send_op(OP_ERASE, 8'd2,   2'd0, '0);           // erased twice: links to itself
        send_op(OP_INSERT, 8'd0,  2'd0, '0);
        send_op(OP_SET,   8'd2,   2'd0, 32'd300);      // overwrite the link, past last record
        send_op(OP_INSERT, 8'd0,  2'd0, '0);           // that link ends the list
        send_op(OP_INSERT, 8'd0,  2'd0, '0);
        send_op(OP_CLEAR, 8'd0,   2'd0, '0);
        send_op(OP_POP,   8'd0,   2'd0, '0);

        // Random part in segments; each gets its own field count, the idle pattern
        // changes every few segments.
        for (int seg = 0; seg < NUM_SEG; seg++) begin
            if (seg == 3) begin
                src_idle_pct = 71;
                dst_idle_pct = 21;
            end else if (seg == 6) begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
            end
            write_fields(seg_fields[seg]);
            if (seg == FILL_SEG) begin
                // Run up to capacity, then hit the full store and the last index.
                while (chk_count < NUM_REC)
                    send_op(OP_PUSH, REC_IDX_W'($urandom), FIELD_SEL_W'($urandom),
                            DATA_W'($urandom));
                send_op(OP_PUSH,   8'd0,   2'd0, '0);
                send_op(OP_INSERT, 8'd0,   2'd0, '0);
                send_op(OP_SET,    8'd255, 2'd0, rand_value());
                send_op(OP_GET,    8'd255, 2'd0, '0);
                send_op(OP_ERASE,  8'd255, 2'd0, '0);
                send_op(OP_INSERT, 8'd0,   2'd0, '0);
            end
            for (int n = 0; n < seg_items[seg]; n++) begin
                make_random_op(op, rec, fld, wval);
                send_op(op, rec, fld, wval);
            end
        end

        // Drain; the watchdog bounds this wait.
        req_ch.valid = 1'b0;
        while (chk_pending != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (chk_fails == 0 && chk_pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### record_store_with_free_list_top.f
src/rsfl_pkg.sv
src/rsfl_chan_if.sv
src/rsfl_front.sv
src/rsfl_back.sv
src/record_store_with_free_list_top.sv
sim/rsfl_store_checker.sv
sim/tb_top.sv
